### rtl/core/mldd_pkg.sv
// shared types and constants for the magic/length datagram deframer
package mldd_pkg;

  // default number of magic bytes the hardware can hold
  localparam int unsigned MagicBytesMaxDef = 8;

  // number of little-endian length bytes after the magic
  localparam int unsigned LenBytes = 4;

  // configuration port geometry
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;

  // field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 32;
  localparam int unsigned MagLenW  = 4;
  localparam int unsigned KindW    = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMagicPattern = 2'd0,
    CfgMagicLength  = 2'd1,
    CfgMaxPayload   = 2'd2
  } cfg_idx_e;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KindData     = 2'd0,
    KindEmpty    = 2'd1,
    KindBadMagic = 2'd2,
    KindTooLarge = 2'd3
  } result_kind_e;

  // scalar configuration seen by the parser
  typedef struct packed {
    logic [MagLenW-1:0] magic_length;
    logic [LenW-1:0]    max_payload;
  } cfg_t;

  // one result word
  typedef struct packed {
    result_kind_e     kind;
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

endpackage

### rtl/core/mldd_cfg.sv
// configuration registers of the deframer
module mldd_cfg #(
  parameter int unsigned MagicBytesMax = mldd_pkg::MagicBytesMaxDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mldd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mldd_pkg::CfgDataW-1:0]       cfg_wdata_i,
  output logic [MagicBytesMax*mldd_pkg::ByteW-1:0] magic_pattern_o,
  output mldd_pkg::cfg_t                      cfg_o
);
  import mldd_pkg::*;

  localparam int unsigned PatW = MagicBytesMax * ByteW;

  logic [PatW-1:0]    pattern_q;
  logic [MagLenW-1:0] mlen_q;
  logic [LenW-1:0]    maxp_q;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      mlen_q    <= MagLenW'(1);
      maxp_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMagicPattern: pattern_q <= cfg_wdata_i[PatW-1:0];
        CfgMagicLength:  mlen_q    <= cfg_wdata_i[MagLenW-1:0];
        CfgMaxPayload:   maxp_q    <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign magic_pattern_o    = pattern_q;
  assign cfg_o.magic_length = mlen_q;
  assign cfg_o.max_payload  = maxp_q;

endmodule

### rtl/core/mldd_parse.sv
// input register and single-pass frame parser
module mldd_parse #(
  parameter int unsigned MagicBytesMax = mldd_pkg::MagicBytesMaxDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mldd_pkg::ByteW-1:0]          stream_byte_i,
  input  logic [MagicBytesMax*mldd_pkg::ByteW-1:0] magic_pattern_i,
  input  mldd_pkg::cfg_t                      cfg_i,
  input  logic                                out_free_i,
  output logic                                res_valid_o,
  output mldd_pkg::result_t                   res_o
);
  import mldd_pkg::*;

  localparam int unsigned IdxW = (MagicBytesMax > 1) ? $clog2(MagicBytesMax) : 1;
  localparam logic [IdxW-1:0]    LastIdx  = IdxW'(MagicBytesMax - 1);
  localparam logic [MagLenW-1:0] MaxLen   = MagLenW'(MagicBytesMax);
  localparam logic [LenW:0]      LenBytesW = (LenW+1)'(LenBytes);

  typedef enum logic [1:0] {
    StMagic   = 2'd0,
    StLength  = 2'd1,
    StPayload = 2'd2
  } parse_stage_e;

  logic             in_vq;
  logic [ByteW-1:0] in_byte_q;
  logic             fire;

  parse_stage_e    stage_q, stage_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic            mism_q, mism_d;
  logic [LenW-1:0] len_q, len_d;

  logic [ByteW-1:0]   pat_bytes [MagicBytesMax];
  logic [IdxW-1:0]    mag_idx;
  logic [ByteW-1:0]   expect_byte;
  logic [MagLenW-1:0] eff_len;
  logic [LenW:0]      pos_inc;
  logic [LenW-1:0]    len_acc;

  // input register, advances when empty or whenever the result side can take a word
  assign fire       = in_vq && out_free_i;
  assign in_ready_o = !in_vq || out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= stream_byte_i;
    end
  end

  // split the magic pattern into bytes
  for (genvar g = 0; g < MagicBytesMax; g++) begin : g_pat
    assign pat_bytes[g] = magic_pattern_i[g*ByteW +: ByteW];
  end

  // expected magic byte, position clamped to the last one
  always_comb begin
    if (pos_q > LenW'(MagicBytesMax - 1)) begin
      mag_idx = LastIdx;
    end else begin
      mag_idx = pos_q[IdxW-1:0];
    end
    expect_byte = pat_bytes[mag_idx];
  end

  // effective magic length, zero used as one, values above MagicBytesMax clamped to it
  always_comb begin
    if (cfg_i.magic_length == '0) begin
      eff_len = MagLenW'(1);
    end else if (cfg_i.magic_length > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = cfg_i.magic_length;
    end
  end

  assign pos_inc = {1'b0, pos_q} + (LenW+1)'(1);
  assign len_acc = len_q | (LenW'(in_byte_q) << {pos_q[1:0], 3'b000});

  // next state and result for the registered byte
  always_comb begin
    stage_d     = stage_q;
    pos_d       = pos_q;
    mism_d      = mism_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o.kind  = KindData;
    res_o.data  = '0;
    res_o.last  = 1'b0;
    case (stage_q)
      StLength: begin
        len_d = len_acc;
        pos_d = pos_inc[LenW-1:0];
        if (pos_inc >= LenBytesW) begin
          if (len_acc > cfg_i.max_payload) begin
            res_valid_o = fire;
            res_o.kind  = KindTooLarge;
            stage_d     = StMagic;
            pos_d       = '0;
            mism_d      = 1'b0;
            len_d       = '0;
          end else if (len_acc == '0) begin
            res_valid_o = fire;
            res_o.kind  = KindEmpty;
            res_o.last  = 1'b1;
            stage_d     = StMagic;
            pos_d       = '0;
            mism_d      = 1'b0;
            len_d       = '0;
          end else begin
            stage_d = StPayload;
            pos_d   = '0;
          end
        end
      end
      StPayload: begin
        res_valid_o = fire;
        res_o.kind  = KindData;
        res_o.data  = in_byte_q;
        pos_d       = pos_inc[LenW-1:0];
        if (pos_inc >= {1'b0, len_q}) begin
          res_o.last = 1'b1;
          stage_d    = StMagic;
          pos_d      = '0;
          mism_d     = 1'b0;
          len_d      = '0;
        end
      end
      default: begin
        stage_d = StMagic;
        pos_d   = pos_inc[LenW-1:0];
        if (in_byte_q != expect_byte) begin
          mism_d = 1'b1;
        end
        if (pos_inc >= (LenW+1)'(eff_len)) begin
          pos_d = '0;
          len_d = '0;
          if (mism_d) begin
            res_valid_o = fire;
            res_o.kind  = KindBadMagic;
            mism_d      = 1'b0;
          end else begin
            stage_d = StLength;
          end
        end
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StMagic;
      pos_q   <= '0;
      mism_q  <= 1'b0;
      len_q   <= '0;
    end else if (fire) begin
      stage_q <= stage_d;
      pos_q   <= pos_d;
      mism_q  <= mism_d;
      len_q   <= len_d;
    end
  end

endmodule

### rtl/core/mldd_out.sv
// result register toward the output channel
module mldd_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           res_valid_i,
  input  mldd_pkg::result_t              res_i,
  output logic                           free_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mldd_pkg::KindW-1:0]     result_kind_o,
  output logic [mldd_pkg::ByteW-1:0]     payload_byte_o,
  output logic                           frame_last_o
);
  import mldd_pkg::*;

  logic    valid_q;
  result_t res_q;

  // free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign result_kind_o  = res_q.kind;
  assign payload_byte_o = res_q.data;
  assign frame_last_o   = res_q.last;

endmodule

### rtl/core/magic_length_datagram_deframer.sv
// top level of the magic/length datagram deframer
//
//   channel  | handshake                  | word
//   ---------+----------------------------+-----------------------------------------
//   input    | in_valid_i / in_ready_o    | stream_byte_i
//   output   | out_valid_o / out_ready_i  | result_kind_o, payload_byte_o, frame_last_o
//   config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// one byte per clock sustained while the output is not stalled; a taken byte is loaded
// into the input register, and any result it yields then into the result register
// reset returns the parser to magic hunting and loads the register defaults
// a stalled output holds the result register; the input register takes a byte while it
// is empty or the result register is empty or draining, so a stall blocks after one more
module magic_length_datagram_deframer #(
  parameter int unsigned MagicBytesMax = mldd_pkg::MagicBytesMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mldd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mldd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mldd_pkg::ByteW-1:0]     stream_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mldd_pkg::KindW-1:0]     result_kind_o,
  output logic [mldd_pkg::ByteW-1:0]     payload_byte_o,
  output logic                           frame_last_o
);
  import mldd_pkg::*;

  logic [MagicBytesMax*ByteW-1:0] magic_pattern;
  cfg_t                           cfg;
  logic                           res_valid;
  result_t                        res;
  logic                           out_free;

  // configuration registers
  mldd_cfg #(
    .MagicBytesMax(MagicBytesMax)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .magic_pattern_o(magic_pattern),
    .cfg_o          (cfg)
  );

  // input register and parser
  mldd_parse #(
    .MagicBytesMax(MagicBytesMax)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .magic_pattern_i(magic_pattern),
    .cfg_i          (cfg),
    .out_free_i     (out_free),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // result register
  mldd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_last_o  (frame_last_o)
  );

endmodule
